### rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helper functions for the json string unescaper
package jsu_pkg;

    // decoder modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_TEXT   = 3'd1;
    localparam logic [2:0] MODE_ESC    = 3'd2;
    localparam logic [2:0] MODE_HEX1   = 3'd3;
    localparam logic [2:0] MODE_SUR_BS = 3'd4;
    localparam logic [2:0] MODE_SUR_U  = 3'd5;
    localparam logic [2:0] MODE_HEX2   = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BAD_HEX = 2'd1;
    localparam logic [1:0] ERR_BAD_SUR = 2'd2;
    localparam logic [1:0] ERR_UNTERM  = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_BS_OUT = 8'h08;
    localparam logic [7:0] CH_FF_OUT = 8'h0c;
    localparam logic [7:0] CH_LF_OUT = 8'h0a;
    localparam logic [7:0] CH_CR_OUT = 8'h0d;
    localparam logic [7:0] CH_HT_OUT = 8'h09;

    localparam logic [15:0] SUR_MASK = 16'hfc00;
    localparam logic [15:0] SUR_HIGH = 16'hd800;
    localparam logic [15:0] SUR_LOW  = 16'hdc00;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_req;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        logic       string_end;
        logic [1:0] error_code;
    } t_out;

    // all results caused by one input transaction
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
        logic            string_end;
        logic [1:0]      error_code;
    } t_bundle;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_bundle utf8_encode(input logic [20:0] cp);
        t_bundle b;
        b = '0;
        if (cp < 21'h80) begin
            b.cnt      = 3'd1;
            b.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            b.cnt      = 3'd2;
            b.bytes[0] = {3'b110, cp[10:6]};
            b.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            b.cnt      = 3'd3;
            b.bytes[0] = {4'b1110, cp[15:12]};
            b.bytes[1] = {2'b10, cp[11:6]};
            b.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            b.cnt      = 3'd4;
            b.bytes[0] = {5'b11110, cp[20:18]};
            b.bytes[1] = {2'b10, cp[17:12]};
            b.bytes[2] = {2'b10, cp[11:6]};
            b.bytes[3] = {2'b10, cp[5:0]};
        end
        return b;
    endfunction

endpackage

### rtl/jsu_decode.sv
`timescale 1ns / 1ps
// escape state machine: decodes one input byte into a bundle of results
module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  jsu_pkg::t_in     i_in,
    output jsu_pkg::t_bundle o_bundle
);

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_dcnt, n_dcnt;
    logic [9:0]  r_hs, n_hs;

    logic [2:0]  mode_eff;
    logic [15:0] hex_eff;
    logic [1:0]  dcnt_eff;
    logic [9:0]  hs_eff;
    logic [7:0]  c;
    logic [15:0] acc;
    jsu_pkg::t_hex    hv;
    jsu_pkg::t_bundle b;

    always_comb begin
        c        = i_in.in_byte;
        // a start request behaves as a reset followed by text mode
        mode_eff = i_in.start_req ? jsu_pkg::MODE_TEXT : r_mode;
        hex_eff  = i_in.start_req ? 16'd0 : r_hex;
        dcnt_eff = i_in.start_req ? 2'd0 : r_dcnt;
        hs_eff   = i_in.start_req ? 10'd0 : r_hs;
        hv       = jsu_pkg::hex_value(c);
        acc      = {hex_eff[11:0], hv.val};

        n_mode = mode_eff;
        n_hex  = hex_eff;
        n_dcnt = dcnt_eff;
        n_hs   = hs_eff;
        b      = '0;

        case (mode_eff)
            jsu_pkg::MODE_TEXT: begin
                if (c == jsu_pkg::CH_NUL) begin
                    b.cnt        = 3'd1;
                    b.error_code = jsu_pkg::ERR_UNTERM;
                    n_mode       = jsu_pkg::MODE_IDLE;
                end else if (c == jsu_pkg::CH_QUOTE) begin
                    b.cnt        = 3'd1;
                    b.string_end = 1'b1;
                    n_mode       = jsu_pkg::MODE_IDLE;
                end else if (c == jsu_pkg::CH_BSLASH) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end else begin
                    b.cnt      = 3'd1;
                    b.bytes[0] = c;
                end
            end
            jsu_pkg::MODE_ESC: begin
                n_mode = jsu_pkg::MODE_TEXT;
                b.cnt  = 3'd1;
                case (c)
                    jsu_pkg::CH_BSLASH,
                    jsu_pkg::CH_SLASH,
                    jsu_pkg::CH_QUOTE: b.bytes[0] = c;
                    jsu_pkg::CH_B:     b.bytes[0] = jsu_pkg::CH_BS_OUT;
                    jsu_pkg::CH_F:     b.bytes[0] = jsu_pkg::CH_FF_OUT;
                    jsu_pkg::CH_N:     b.bytes[0] = jsu_pkg::CH_LF_OUT;
                    jsu_pkg::CH_R:     b.bytes[0] = jsu_pkg::CH_CR_OUT;
                    jsu_pkg::CH_T:     b.bytes[0] = jsu_pkg::CH_HT_OUT;
                    jsu_pkg::CH_U: begin
                        b.cnt  = 3'd0;
                        n_mode = jsu_pkg::MODE_HEX1;
                        n_hex  = 16'd0;
                        n_dcnt = 2'd0;
                    end
                    jsu_pkg::CH_NUL: begin
                        b.error_code = jsu_pkg::ERR_UNTERM;
                        n_mode       = jsu_pkg::MODE_IDLE;
                    end
                    default: begin
                        // unknown escape keeps its backslash
                        b.cnt      = 3'd2;
                        b.bytes[0] = jsu_pkg::CH_BSLASH;
                        b.bytes[1] = c;
                    end
                endcase
            end
            jsu_pkg::MODE_HEX1,
            jsu_pkg::MODE_HEX2: begin
                if (!hv.ok) begin
                    b.cnt        = 3'd1;
                    b.error_code = (mode_eff == jsu_pkg::MODE_HEX1) ?
                                   jsu_pkg::ERR_BAD_HEX : jsu_pkg::ERR_BAD_SUR;
                    n_mode       = jsu_pkg::MODE_IDLE;
                end else begin
                    n_hex = acc;
                    if (dcnt_eff != 2'd3) begin
                        n_dcnt = dcnt_eff + 2'd1;
                    end else begin
                        n_dcnt = 2'd0;
                        if (mode_eff == jsu_pkg::MODE_HEX1) begin
                            if ((acc & jsu_pkg::SUR_MASK) == jsu_pkg::SUR_HIGH) begin
                                n_hs   = acc[9:0];
                                n_mode = jsu_pkg::MODE_SUR_BS;
                            end else begin
                                b      = jsu_pkg::utf8_encode({5'd0, acc});
                                n_mode = jsu_pkg::MODE_TEXT;
                            end
                        end else if ((acc & jsu_pkg::SUR_MASK) != jsu_pkg::SUR_LOW) begin
                            b.cnt        = 3'd1;
                            b.error_code = jsu_pkg::ERR_BAD_SUR;
                            n_mode       = jsu_pkg::MODE_IDLE;
                        end else begin
                            b      = jsu_pkg::utf8_encode(jsu_pkg::SUPP_BASE +
                                                          {1'b0, hs_eff, acc[9:0]});
                            n_mode = jsu_pkg::MODE_TEXT;
                        end
                    end
                end
            end
            jsu_pkg::MODE_SUR_BS: begin
                if (c == jsu_pkg::CH_BSLASH) begin
                    n_mode = jsu_pkg::MODE_SUR_U;
                end else begin
                    b.cnt        = 3'd1;
                    b.error_code = jsu_pkg::ERR_BAD_SUR;
                    n_mode       = jsu_pkg::MODE_IDLE;
                end
            end
            jsu_pkg::MODE_SUR_U: begin
                if (c == jsu_pkg::CH_U) begin
                    n_mode = jsu_pkg::MODE_HEX2;
                    n_hex  = 16'd0;
                    n_dcnt = 2'd0;
                end else begin
                    b.cnt        = 3'd1;
                    b.error_code = jsu_pkg::ERR_BAD_SUR;
                    n_mode       = jsu_pkg::MODE_IDLE;
                end
            end
            default: begin
                n_mode = jsu_pkg::MODE_IDLE;
            end
        endcase
        o_bundle = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_IDLE;
            r_hex  <= 16'd0;
            r_dcnt <= 2'd0;
            r_hs   <= 10'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_dcnt <= n_dcnt;
            r_hs   <= n_hs;
        end
    end

    property p_idle_silent;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == jsu_pkg::MODE_IDLE && !i_in.start_req) |-> (o_bundle.cnt == 3'd0);
    endproperty
    a_idle_silent: assert property (p_idle_silent)
        else $error("idle decoder produced results");

    property p_status_single;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_bundle.string_end || o_bundle.error_code != jsu_pkg::ERR_NONE)
            |-> (o_bundle.cnt == 3'd1);
    endproperty
    a_status_single: assert property (p_status_single)
        else $error("status result not alone in its bundle");

    property p_err_to_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_bundle.error_code != jsu_pkg::ERR_NONE)
            |=> (r_mode == jsu_pkg::MODE_IDLE);
    endproperty
    a_err_to_idle: assert property (p_err_to_idle)
        else $error("decoder left running after an error");

endmodule

### rtl/jsu_out.sv
`timescale 1ns / 1ps
// result register: holds one bundle and drains it one result per transaction
module jsu_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    input  logic             i_out_ready,
    output logic             o_can_load,
    output logic             o_out_valid,
    output jsu_pkg::t_out    o_out
);

    logic            r_busy, n_busy;
    logic [1:0]      r_idx, n_idx;
    logic [1:0]      r_last;
    logic [3:0][7:0] r_bytes;
    logic            r_end;
    logic [1:0]      r_err;
    logic            push;
    logic            pop;
    logic            at_last;

    assign at_last     = (r_idx == r_last);
    assign pop         = r_busy && i_out_ready;
    assign push        = i_load && (i_bundle.cnt != 3'd0);
    assign o_can_load  = !r_busy || (at_last && i_out_ready);
    assign o_out_valid = r_busy;

    always_comb begin
        o_out.out_byte   = r_bytes[r_idx];
        o_out.has_byte   = !r_end && (r_err == jsu_pkg::ERR_NONE);
        o_out.last       = at_last;
        o_out.string_end = r_end;
        o_out.error_code = r_err;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (push) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (pop) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_last  <= 2'(i_bundle.cnt - 3'd1);
            r_bytes <= i_bundle.bytes;
            r_end   <= i_bundle.string_end;
            r_err   <= i_bundle.error_code;
        end
    end

    property p_load_when_free;
        @(posedge i_clk) disable iff (!i_rst_n)
        push |-> o_can_load;
    endproperty
    a_load_when_free: assert property (p_load_when_free)
        else $error("bundle loaded over undrained results");

    property p_no_early_drop;
        @(posedge i_clk) disable iff (!i_rst_n)
        (pop && !at_last) |=> (r_busy && r_idx == $past(r_idx) + 2'd1);
    endproperty
    a_no_early_drop: assert property (p_no_early_drop)
        else $error("bundle dropped before its last result");

    property p_idx_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last);
    endproperty
    a_idx_in_range: assert property (p_idx_in_range)
        else $error("result index beyond bundle length");

endmodule

### rtl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// top level of the json string unescaper with utf-8 output
//
//  channel  valid         ready         payload                     direction
//  input    i_in_valid    o_in_ready    i_in  (jsu_pkg::t_in)       in
//  output   o_out_valid   i_out_ready   o_out (jsu_pkg::t_out)      out
//
// one input byte per cycle is taken while the result register can load;
// its results appear in the next cycle; an input byte gives 0 to 4 results,
// drained one per cycle while the output is ready, so a byte that ends a \u
// escape holds input off; input is taken on the cycle the last result leaves
// synchronous active-low reset leaves the decoder idle until a start request
module json_string_unescape_utf8 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  jsu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output jsu_pkg::t_out o_out
);

    logic             accept;
    logic             can_load;
    jsu_pkg::t_bundle bundle;

    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_bundle (bundle)
    );

    jsu_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_bundle    (bundle),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

### verif/json_string_unescape_utf8_checker.sv
`timescale 1ns / 1ps
// checker for the json string unescaper: predicts the decoded results and compares them
module json_string_unescape_utf8_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  jsu_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  jsu_pkg::t_out i_out,
    output int            o_errors,
    output int            o_pending
);
    import jsu_pkg::*;

    logic [2:0]  dec_mode = MODE_IDLE;
    logic [15:0] hex_acc  = '0;
    logic [1:0]  hex_cnt  = '0;
    logic [9:0]  hi_sur   = '0;
    t_out        byte_results[$];
    t_out        decoded_q[$];
    t_out        want;
    int          err_cnt  = 0;

    assign o_errors  = err_cnt;
    assign o_pending = decoded_q.size();

    task automatic report_mismatch(input string msg);
        // keep the log short if the block is badly off
        if (err_cnt < 100) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    function automatic t_out make_res(input logic [7:0] b, input logic has,
                                      input logic fin, input logic [1:0] err);
        t_out r;
        r.out_byte   = b;
        r.has_byte   = has;
        r.last       = 1'b0;
        r.string_end = fin;
        r.error_code = err;
        return r;
    endfunction

    function automatic int hex_digit_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return int'(c) - 'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return int'(c) - 'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return int'(c) - 'h37;
        end
        return -1;
    endfunction

    task automatic abort_string(input logic [1:0] err);
        byte_results.push_back(make_res(8'h00, 1'b0, 1'b0, err));
        dec_mode = MODE_IDLE;
    endtask

    task automatic push_codepoint(input logic [20:0] cp);
        if (cp < 21'h80) begin
            byte_results.push_back(make_res(cp[7:0], 1'b1, 1'b0, ERR_NONE));
        end else if (cp < 21'h800) begin
            byte_results.push_back(make_res(8'hc0 | 8'(cp >> 6), 1'b1, 1'b0, ERR_NONE));
            byte_results.push_back(make_res(8'h80 | 8'(cp & 21'h3f), 1'b1, 1'b0, ERR_NONE));
        end else if (cp < 21'h10000) begin
            byte_results.push_back(make_res(8'he0 | 8'(cp >> 12), 1'b1, 1'b0, ERR_NONE));
            byte_results.push_back(make_res(8'h80 | 8'((cp >> 6) & 21'h3f), 1'b1, 1'b0,
                                            ERR_NONE));
            byte_results.push_back(make_res(8'h80 | 8'(cp & 21'h3f), 1'b1, 1'b0, ERR_NONE));
        end else begin
            byte_results.push_back(make_res(8'hf0 | 8'((cp >> 18) & 21'h07), 1'b1, 1'b0,
                                            ERR_NONE));
            byte_results.push_back(make_res(8'h80 | 8'((cp >> 12) & 21'h3f), 1'b1, 1'b0,
                                            ERR_NONE));
            byte_results.push_back(make_res(8'h80 | 8'((cp >> 6) & 21'h3f), 1'b1, 1'b0,
                                            ERR_NONE));
            byte_results.push_back(make_res(8'h80 | 8'(cp & 21'h3f), 1'b1, 1'b0, ERR_NONE));
        end
    endtask

    task automatic plain_char(input logic [7:0] c);
        if (c == CH_NUL) begin
            abort_string(ERR_UNTERM);
        end else if (c == CH_QUOTE) begin
            byte_results.push_back(make_res(8'h00, 1'b0, 1'b1, ERR_NONE));
            dec_mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            byte_results.push_back(make_res(c, 1'b1, 1'b0, ERR_NONE));
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic start);
        int   d;
        t_out tail;
        byte_results.delete();
        if (start) begin
            hex_acc  = '0;
            hex_cnt  = '0;
            hi_sur   = '0;
            dec_mode = MODE_TEXT;
        end
        case (dec_mode)
            MODE_TEXT: begin
                plain_char(c);
            end
            MODE_ESC: begin
                dec_mode = MODE_TEXT;
                case (c)
                    CH_BSLASH, CH_SLASH, CH_QUOTE: begin
                        byte_results.push_back(make_res(c, 1'b1, 1'b0, ERR_NONE));
                    end
                    CH_B: byte_results.push_back(make_res(CH_BS_OUT, 1'b1, 1'b0, ERR_NONE));
                    CH_F: byte_results.push_back(make_res(CH_FF_OUT, 1'b1, 1'b0, ERR_NONE));
                    CH_N: byte_results.push_back(make_res(CH_LF_OUT, 1'b1, 1'b0, ERR_NONE));
                    CH_R: byte_results.push_back(make_res(CH_CR_OUT, 1'b1, 1'b0, ERR_NONE));
                    CH_T: byte_results.push_back(make_res(CH_HT_OUT, 1'b1, 1'b0, ERR_NONE));
                    CH_U: begin
                        dec_mode = MODE_HEX1;
                        hex_acc  = '0;
                        hex_cnt  = '0;
                    end
                    CH_NUL: begin
                        abort_string(ERR_UNTERM);
                    end
                    default: begin
                        // unknown escape keeps its backslash
                        byte_results.push_back(make_res(CH_BSLASH, 1'b1, 1'b0, ERR_NONE));
                        plain_char(c);
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2: begin
                d = hex_digit_val(c);
                if (d < 0) begin
                    abort_string(dec_mode == MODE_HEX1 ? ERR_BAD_HEX : ERR_BAD_SUR);
                end else begin
                    hex_acc = {hex_acc[11:0], 4'(d)};
                    if (hex_cnt != 2'd3) begin
                        hex_cnt++;
                    end else begin
                        hex_cnt = '0;
                        if (dec_mode == MODE_HEX1) begin
                            if ((hex_acc & SUR_MASK) == SUR_HIGH) begin
                                hi_sur   = hex_acc[9:0];
                                dec_mode = MODE_SUR_BS;
                            end else begin
                                push_codepoint({5'd0, hex_acc});
                                dec_mode = MODE_TEXT;
                            end
                        end else if ((hex_acc & SUR_MASK) != SUR_LOW) begin
                            abort_string(ERR_BAD_SUR);
                        end else begin
                            push_codepoint(SUPP_BASE + {1'b0, hi_sur, hex_acc[9:0]});
                            dec_mode = MODE_TEXT;
                        end
                    end
                end
            end
            MODE_SUR_BS: begin
                if (c == CH_BSLASH) begin
                    dec_mode = MODE_SUR_U;
                end else begin
                    abort_string(ERR_BAD_SUR);
                end
            end
            MODE_SUR_U: begin
                if (c == CH_U) begin
                    dec_mode = MODE_HEX2;
                    hex_acc  = '0;
                    hex_cnt  = '0;
                end else begin
                    abort_string(ERR_BAD_SUR);
                end
            end
            default: begin
                dec_mode = MODE_IDLE;
            end
        endcase
        if (byte_results.size() > 0) begin
            tail = byte_results.pop_back();
            tail.last = 1'b1;
            byte_results.push_back(tail);
        end
        foreach (byte_results[i]) begin
            decoded_q.push_back(byte_results[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_mode = MODE_IDLE;
            hex_acc  = '0;
            hex_cnt  = '0;
            hi_sur   = '0;
            decoded_q.delete();
        end else begin
            // results on the output always belong to earlier input transactions
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result byte=%02h has=%b last=%b end=%b err=%0d",
                        i_out.out_byte, i_out.has_byte, i_out.last,
                        i_out.string_end, i_out.error_code));
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out.out_byte !== want.out_byte || i_out.has_byte !== want.has_byte ||
                        i_out.last !== want.last || i_out.string_end !== want.string_end ||
                        i_out.error_code !== want.error_code) begin
                        // fields in order: byte has last end err
                        report_mismatch($sformatf(
                            "got %02h %b %b %b %0d, want %02h %b %b %b %0d",
                            i_out.out_byte, i_out.has_byte, i_out.last, i_out.string_end,
                            i_out.error_code, want.out_byte, want.has_byte, want.last,
                            want.string_end, want.error_code));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_in.in_byte, i_in.start_req);
            end
        end
    end

endmodule

### verif/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps
// testbench top for the json string unescaper: stimulus, flow control and verdict
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;
    localparam int TAIL_CYCLES    = 10;
    localparam int PHASE_BYTES    = 90;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    t_in   in_pay    = '0;
    logic  out_ready = 1'b0;
    logic  in_ready;
    logic  out_valid;
    t_out  out_pay;
    int    err_total;
    int    pend_total;

    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    bit    hold_req       = 1'b0;
    bit    start_next     = 1'b0;
    int    body_bytes     = 0;

    json_string_unescape_utf8 u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_pay),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_pay)
    );

    json_string_unescape_utf8_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_pay),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_pay),
        .o_errors    (err_total),
        .o_pending   (pend_total)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        c = 8'(($urandom_range(255)));
        while (is_hex(c)) begin
            c = 8'(($urandom_range(255)));
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int   gap;
        t_in  p;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 8) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        p.in_byte   = b;
        p.start_req = s;
        in_valid <= 1'b1;
        in_pay   <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // byte of a string body; the first one of a string carries the start request
    task automatic body_byte(input logic [7:0] b);
        send_byte(b, start_next);
        start_next = 1'b0;
        body_bytes++;
    endtask

    task automatic send_hex16(input logic [15:0] v);
        for (int i = 3; i >= 0; i--) begin
            body_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(1))));
        end
    endtask

    task automatic send_escape_u(input logic [15:0] v);
        body_byte(CH_BSLASH);
        body_byte(CH_U);
        send_hex16(v);
    endtask

    task automatic send_partial_hex();
        int ndig;
        ndig = $urandom_range(3);
        repeat (ndig) body_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        body_byte(non_hex_byte());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pend_total != 0);
    endtask

    task automatic send_error_tail();
        logic [7:0]  c;
        logic [15:0] v;
        case ($urandom_range(5))
            0: body_byte(CH_NUL);
            1: begin
                body_byte(CH_BSLASH);
                body_byte(CH_NUL);
            end
            2: begin
                body_byte(CH_BSLASH);
                body_byte(CH_U);
                send_partial_hex();
            end
            3: begin
                send_escape_u(SUR_HIGH | 16'($urandom_range(1023)));
                c = 8'($urandom_range(255));
                if (c == CH_BSLASH) c = CH_U;
                body_byte(c);
            end
            4: begin
                send_escape_u(SUR_HIGH | 16'($urandom_range(1023)));
                body_byte(CH_BSLASH);
                c = 8'($urandom_range(255));
                if (c == CH_U) c = CH_BSLASH;
                body_byte(c);
            end
            default: begin
                send_escape_u(SUR_HIGH | 16'($urandom_range(1023)));
                body_byte(CH_BSLASH);
                body_byte(CH_U);
                if ($urandom_range(1)) begin
                    send_partial_hex();
                end else begin
                    // four good digits that do not form a low surrogate
                    v = 16'($urandom_range(16'hffff));
                    if ((v & SUR_MASK) == SUR_LOW) v = v ^ 16'h4000;
                    send_hex16(v);
                end
            end
        endcase
    endtask

    task automatic send_random_string();
        int          npieces;
        int          kind;
        int          ending;
        logic [7:0]  c;
        logic [15:0] v;
        start_next = 1'b1;
        npieces = $urandom_range(8, 1);
        repeat (npieces) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                c = 8'($urandom_range(255, 1));
                while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(255, 1));
                body_byte(c);
            end else if (kind < 50) begin
                body_byte(CH_BSLASH);
                case ($urandom_range(7))
                    0: body_byte(CH_BSLASH);
                    1: body_byte(CH_SLASH);
                    2: body_byte(CH_QUOTE);
                    3: body_byte(CH_B);
                    4: body_byte(CH_F);
                    5: body_byte(CH_N);
                    6: body_byte(CH_R);
                    default: body_byte(CH_T);
                endcase
            end else if (kind < 55) begin
                c = 8'($urandom_range(255, 1));
                while (c == CH_U) c = 8'($urandom_range(255, 1));
                body_byte(CH_BSLASH);
                body_byte(c);
            end else if (kind < 80) begin
                case ($urandom_range(3))
                    0: v = 16'($urandom_range(16'h7f));
                    1: v = 16'($urandom_range(16'h7ff, 16'h80));
                    2: begin
                        v = 16'($urandom_range(16'hffff, 16'h800));
                        if ((v & SUR_MASK) == SUR_HIGH) v = v ^ 16'h0800;
                    end
                    default: v = SUR_LOW | 16'($urandom_range(1023));
                endcase
                send_escape_u(v);
            end else begin
                send_escape_u(SUR_HIGH | 16'($urandom_range(1023)));
                send_escape_u(SUR_LOW | 16'($urandom_range(1023)));
            end
        end
        ending = $urandom_range(99);
        if (ending < 88) begin
            if (ending < 70) begin
                body_byte(CH_QUOTE);
            end else begin
                send_error_tail();
            end
            // the decoder is idle now, so these are dropped
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    task automatic run_directed();
        // extremes, a kept backslash and the closing quote
        start_next = 1'b1;
        body_byte(8'h01);
        body_byte(8'hff);
        body_byte(CH_BSLASH);
        body_byte(CH_QUOTE);
        body_byte(CH_BSLASH);
        body_byte(8'h71);
        body_byte(CH_QUOTE);
        send_byte(8'h61, 1'b0);
        // surrogate pair, then a zero byte in the body
        start_next = 1'b1;
        send_escape_u(16'hd83d);
        send_escape_u(16'hde00);
        body_byte(CH_NUL);
        // zero byte right after a backslash
        start_next = 1'b1;
        body_byte(CH_BSLASH);
        body_byte(CH_NUL);
        // bad hex digit in the first escape
        start_next = 1'b1;
        body_byte(CH_BSLASH);
        body_byte(CH_U);
        body_byte(8'h67);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
        int target;
        bit held;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = body_bytes + PHASE_BYTES;
        held   = 1'b0;
        while (body_bytes < target) begin
            if (long_hold && !held && body_bytes >= target - PHASE_BYTES / 2) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            send_random_string();
        end
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_phase(0, 0, 1'b1);
        run_phase(45, 0, 1'b0);
        run_phase(0, 45, 1'b0);
        run_phase(30, 30, 1'b0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_total == 0 && pend_total == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### json_string_unescape_utf8.f
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_out.sv
rtl/json_string_unescape_utf8.sv
verif/json_string_unescape_utf8_checker.sv
verif/json_string_unescape_utf8_tb.sv
